// ===== sv/rgmm_pkg.sv =====
package rgmm_pkg;

  localparam int unsigned PIX_W = 8;
  localparam int unsigned WS_W  = 4;
  localparam int unsigned IDX_W = 2;

  localparam logic [IDX_W-1:0] REG_WINDOW_SIZE = IDX_W'(0);
  localparam logic [IDX_W-1:0] REG_MODE        = IDX_W'(1);

  localparam logic MODE_DILATE = 1'b0;
  localparam logic MODE_ERODE  = 1'b1;

  // one history cell: stored pixel plus running max/min back to the newest pixel
  typedef struct packed {
    logic [PIX_W-1:0] pix;
    logic [PIX_W-1:0] rmax;
    logic [PIX_W-1:0] rmin;
  } cell_t;

endpackage

// ===== sv/row_gray_min_max_filter.sv =====
// Row-wise grayscale dilation (mode 0, max) or erosion (mode 1, min) over a
// centred window of s = window_size|1 pixels (clamped to the largest odd
// value <= MAX_WINDOW). A chain of MAX_WINDOW cells shifts the pixel history
// and keeps running max/min, so a full window's extreme is read from one cell.
// One pixel is taken and one leaves per clock unless stalled, s/2 pixels
// behind. The tlast pixel emits min(position, s/2)+1 results, one per cycle
// unless stalled, input held off. s_axis_tready follows m_axis_tready at once.
module row_gray_min_max_filter #(
  parameter int unsigned MAX_WINDOW = 15
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [7:0]                        s_axis_tdata,   // [7:0] pixel
  input  logic                              s_axis_tlast,   // last_of_row
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [7:0]                        m_axis_tdata,   // [7:0] out_pixel
  output logic                              m_axis_tlast,   // out_last_of_row
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [rgmm_pkg::IDX_W-1:0]        cfg_index,
  input  logic [rgmm_pkg::WS_W-1:0]         cfg_data
);

  localparam int unsigned IW   = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int unsigned PW   = $clog2(MAX_WINDOW + 1);
  localparam int unsigned SLIM = ((MAX_WINDOW % 2) == 1) ? MAX_WINDOW : MAX_WINDOW - 1;

  logic [rgmm_pkg::WS_W-1:0] window_size;
  logic                      mode;
  logic [PW-1:0]             row_pos;

  logic          job_valid;
  logic [IW-1:0] job_k;
  logic [IW-1:0] job_top;
  logic          job_last;
  logic          job_filt;

  logic                       out_valid;
  logic [rgmm_pkg::PIX_W-1:0] out_pix;
  logic                       out_last;

  rgmm_pkg::cell_t cells [MAX_WINDOW];

  logic [31:0]   win;
  logic [31:0]   half;
  logic [31:0]   pos32;
  logic [IW-1:0] half_idx;
  logic [IW-1:0] top_idx;
  logic          out_load;
  logic          job_fin;
  logic          acc;
  logic          emit_any;
  logic [IW-1:0] first_k;
  logic          pos_ge_h;
  logic [rgmm_pkg::PIX_W-1:0] emit_pix;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      window_size <= rgmm_pkg::WS_W'(3);
      mode        <= rgmm_pkg::MODE_DILATE;
    end else if (cfg_valid) begin
      case (cfg_index)
        rgmm_pkg::REG_WINDOW_SIZE: window_size <= cfg_data;
        rgmm_pkg::REG_MODE:        mode <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    win = {28'd0, window_size | rgmm_pkg::WS_W'(1)};
    if (win > SLIM) begin
      win = SLIM;
    end
    half     = win >> 1;
    pos32    = 32'(row_pos);
    half_idx = IW'(half);
    top_idx  = IW'(half << 1);
    pos_ge_h = pos32 >= half;
    first_k  = (s_axis_tlast && !pos_ge_h) ? IW'(row_pos) : half_idx;
    emit_any = s_axis_tlast || pos_ge_h;
  end

  assign out_load      = !out_valid || m_axis_tready;
  assign job_fin       = job_valid && out_load && (!job_last || job_k == '0);
  assign s_axis_tready = !job_valid || job_fin;
  assign acc           = s_axis_tvalid && s_axis_tready;

  for (genvar i = 0; i < MAX_WINDOW; i++) begin : g_cell
    rgmm_pkg::cell_t prev;
    if (i == 0) begin : g_head
      assign prev = '{pix: s_axis_tdata, rmax: s_axis_tdata, rmin: s_axis_tdata};
    end else begin : g_body
      assign prev = cells[i-1];
    end
    rgmm_cell u_cell (
      .clk   (clk),
      .rst   (rst),
      .shift (acc),
      .pix_in(s_axis_tdata),
      .prev  (prev),
      .cur   (cells[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_pos <= '0;
    end else if (acc) begin
      if (s_axis_tlast) begin
        row_pos <= '0;
      end else if (32'(row_pos) < MAX_WINDOW) begin
        row_pos <= row_pos + PW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      job_valid <= 1'b0;
      job_k     <= '0;
      job_top   <= '0;
      job_last  <= 1'b0;
      job_filt  <= 1'b0;
    end else if (acc) begin
      job_valid <= emit_any;
      job_k     <= first_k;
      job_top   <= top_idx;
      job_last  <= s_axis_tlast;
      job_filt  <= pos32 >= (half << 1);
    end else if (job_valid && out_load) begin
      if (job_fin) begin
        job_valid <= 1'b0;
      end else begin
        job_k    <= job_k - IW'(1);
        job_filt <= 1'b0;
      end
    end
  end

  always_comb begin
    if (job_filt) begin
      emit_pix = (mode == rgmm_pkg::MODE_ERODE) ? cells[job_top].rmin : cells[job_top].rmax;
    end else begin
      emit_pix = cells[job_k].pix;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= job_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load && job_valid) begin
      out_pix  <= emit_pix;
      out_last <= job_last && (job_k == '0);
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = out_pix;
  assign m_axis_tlast  = out_last;

endmodule

// ===== sv/rgmm_cell.sv =====
module rgmm_cell (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         shift,
  input  logic [rgmm_pkg::PIX_W-1:0]   pix_in,
  input  rgmm_pkg::cell_t              prev,
  output rgmm_pkg::cell_t              cur
);

  rgmm_pkg::cell_t cur_next;

  always_comb begin
    cur_next.pix  = prev.pix;
    cur_next.rmax = (pix_in > prev.rmax) ? pix_in : prev.rmax;
    cur_next.rmin = (pix_in < prev.rmin) ? pix_in : prev.rmin;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur <= '0;
    end else if (shift) begin
      cur <= cur_next;
    end
  end

endmodule

// ===== test/tb.sv =====
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned HIST_DEPTH = 15;
  localparam int unsigned CYCLE_LIMIT = 300000;
  localparam int unsigned SETTLE_CYCLES = 32;
  localparam int unsigned ROW_PIXELS = 10;
  localparam int PICK_RANDOM = -1;
  localparam int MD_DIL = int'(rgmm_pkg::MODE_DILATE);
  localparam int MD_ERO = int'(rgmm_pkg::MODE_ERODE);
  localparam logic [rgmm_pkg::IDX_W-1:0] REG_SPARE = rgmm_pkg::IDX_W'(2);

  typedef struct packed {
    logic [rgmm_pkg::PIX_W-1:0] pix;
    logic                       last;
  } row_pixel_t;

  class minmax_scoreboard;
    logic [rgmm_pkg::PIX_W-1:0] history[HIST_DEPTH];
    int unsigned                row_pos;
    logic [rgmm_pkg::WS_W-1:0]  win_size;
    logic                       mode;
    row_pixel_t                 expected_pixels[$];
    int unsigned                errors;

    function new();
      win_size = rgmm_pkg::WS_W'(3);
      mode = rgmm_pkg::MODE_DILATE;
      foreach (history[i]) history[i] = '0;
      row_pos = 0;
      errors = 0;
    endfunction

    function void write_reg(logic [rgmm_pkg::IDX_W-1:0] idx, logic [rgmm_pkg::WS_W-1:0] val);
      if (idx == rgmm_pkg::REG_WINDOW_SIZE) win_size = val;
      else if (idx == rgmm_pkg::REG_MODE) mode = val[0];
    endfunction

    function logic [rgmm_pkg::PIX_W-1:0] window_extreme(int unsigned span);
      logic [rgmm_pkg::PIX_W-1:0] acc;
      acc = history[0];
      for (int unsigned i = 1; i <= span; i++) begin
        if (mode == rgmm_pkg::MODE_DILATE) begin
          if (history[i] > acc) acc = history[i];
        end else begin
          if (history[i] < acc) acc = history[i];
        end
      end
      return acc;
    endfunction

    // shift the new pixel in and queue whatever it releases
    function void note_pixel(logic [rgmm_pkg::PIX_W-1:0] pix, logic last);
      int unsigned s, h, p;
      int first_k, low_k;
      row_pixel_t r;
      s = int'({win_size[rgmm_pkg::WS_W-1:1], 1'b1});
      h = s / 2;
      p = row_pos;
      for (int i = HIST_DEPTH - 1; i > 0; i--) history[i] = history[i-1];
      history[0] = pix;
      if (last || p >= h) begin
        first_k = last ? ((p < h) ? p : h) : h;
        low_k = last ? 0 : h;
        for (int k = first_k; k >= low_k; k--) begin
          if (k == h && p >= 2 * h) r.pix = window_extreme(2 * h);
          else r.pix = history[k];
          r.last = last && (k == 0);
          expected_pixels.push_back(r);
        end
      end
      if (last) row_pos = 0;
      else if (row_pos < HIST_DEPTH) row_pos++;
    endfunction

    function void check_out(logic [rgmm_pkg::PIX_W-1:0] pix, logic last);
      row_pixel_t e;
      if (expected_pixels.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected output pixel %0d last %0b", pix, last);
        return;
      end
      e = expected_pixels.pop_front();
      if (e.pix !== pix || e.last !== last) begin
        errors++;
        if (errors <= 10)
          $display("pixel mismatch: expected %0d last %0b, got %0d last %0b",
                   e.pix, e.last, pix, last);
      end
    endfunction
  endclass

  logic                       clk = 1'b0;
  logic                       rst = 1'b1;
  logic                       s_axis_tvalid = 1'b0;
  logic                       s_axis_tready;
  logic [7:0]                 s_axis_tdata = '0;
  logic                       s_axis_tlast = 1'b0;
  logic                       m_axis_tvalid;
  logic                       m_axis_tready = 1'b0;
  logic [7:0]                 m_axis_tdata;
  logic                       m_axis_tlast;
  logic                       cfg_valid = 1'b0;
  logic                       cfg_ready;
  logic [rgmm_pkg::IDX_W-1:0] cfg_index = '0;
  logic [rgmm_pkg::WS_W-1:0]  cfg_data = '0;

  minmax_scoreboard sb = new();
  int unsigned src_idle = 0;
  int unsigned sink_idle = 0;
  int unsigned cycles = 0;
  logic        got;
  logic [7:0]  got_pix;
  logic        got_last;

  row_gray_min_max_filter u_top (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // sample at the edge, check at the following falling edge
  always @(posedge clk) begin
    got = !rst && m_axis_tvalid && m_axis_tready;
    got_pix = m_axis_tdata;
    got_last = m_axis_tlast;
    m_axis_tready <= ($urandom_range(0, 99) >= sink_idle);
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
    if (got) begin
      @(negedge clk);
      sb.check_out(got_pix, got_last);
    end
  end

  task automatic send_pixel(input logic [7:0] pix, input logic last);
    while ($urandom_range(0, 99) < src_idle) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= pix;
    s_axis_tlast <= last;
    do @(posedge clk); while (!s_axis_tready);
    sb.note_pixel(pix, last);
  endtask

  task automatic send_row(input int unsigned len);
    int unsigned r;
    logic [7:0] pix;
    for (int unsigned i = 0; i < len; i++) begin
      r = $urandom_range(0, 9);
      if (r == 0) pix = 8'h00;
      else if (r == 1) pix = 8'hff;
      else pix = 8'($urandom_range(0, 255));
      send_pixel(pix, i == len - 1);
    end
  endtask

  task automatic write_reg(input logic [rgmm_pkg::IDX_W-1:0] idx,
                           input logic [rgmm_pkg::WS_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    sb.write_reg(idx, val);
  endtask

  task automatic configure(input logic [rgmm_pkg::WS_W-1:0] ws, input logic md,
                           input bit spare);
    write_reg(rgmm_pkg::REG_WINDOW_SIZE, ws);
    write_reg(rgmm_pkg::REG_MODE, rgmm_pkg::WS_W'(md));
    if (spare)
      write_reg(REG_SPARE + rgmm_pkg::IDX_W'($urandom_range(0, 1)),
                rgmm_pkg::WS_W'($urandom_range(0, 15)));
    cfg_valid <= 1'b0;
  endtask

  // wait for every expected pixel, then let in-flight pixels settle
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (sb.expected_pixels.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin
    int seg_ws[9];
    int seg_mode[9];
    int unsigned sent, len;
    logic [rgmm_pkg::WS_W-1:0] ws;
    logic md;
    seg_ws = '{15, 0, PICK_RANDOM, 14, 1, PICK_RANDOM, 7, PICK_RANDOM, 3};
    seg_mode = '{MD_DIL, MD_ERO, PICK_RANDOM, MD_ERO, MD_DIL, PICK_RANDOM,
                 MD_ERO, PICK_RANDOM, MD_DIL};
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset setting: window 3, dilation
    send_pixel(8'd255, 1'b1);
    send_pixel(8'd0, 1'b0);
    send_pixel(8'd255, 1'b0);
    send_pixel(8'd0, 1'b0);
    send_pixel(8'd128, 1'b0);
    send_pixel(8'd1, 1'b1);
    drain();
    // window of one, erosion
    configure(rgmm_pkg::WS_W'(0), rgmm_pkg::MODE_ERODE, 1'b1);
    send_pixel(8'd255, 1'b0);
    send_pixel(8'd0, 1'b0);
    send_pixel(8'd85, 1'b1);
    drain();
    // window changed in the middle of a row
    configure(rgmm_pkg::WS_W'(5), rgmm_pkg::MODE_DILATE, 1'b0);
    send_pixel(8'd7, 1'b0);
    send_pixel(8'd200, 1'b0);
    send_pixel(8'd3, 1'b0);
    send_pixel(8'd9, 1'b0);
    drain();
    configure(rgmm_pkg::WS_W'(3), rgmm_pkg::MODE_DILATE, 1'b0);
    send_pixel(8'd1, 1'b0);
    send_pixel(8'd2, 1'b1);
    drain();

    for (int seg = 0; seg < 9; seg++) begin
      case (seg / 3)
        0: begin
          src_idle = 10;
          sink_idle = 83;
        end
        1: begin
          src_idle = 83;
          sink_idle = 10;
        end
        default: begin
          src_idle = 0;
          sink_idle = 0;
        end
      endcase
      ws = (seg_ws[seg] == PICK_RANDOM) ? rgmm_pkg::WS_W'($urandom_range(0, 15))
                                        : rgmm_pkg::WS_W'(seg_ws[seg]);
      md = (seg_mode[seg] == PICK_RANDOM) ? 1'($urandom_range(0, 1)) : 1'(seg_mode[seg]);
      configure(ws, md, seg % 3 == 2);
      sent = 0;
      while (sent < ROW_PIXELS) begin
        len = ($urandom_range(0, 4) == 0) ? $urandom_range(13, 24) : $urandom_range(1, 12);
        send_row(len);
        sent += len;
      end
      drain();
    end

    if (sb.errors == 0 && sb.expected_pixels.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
